// File: src/fis_pkg.sv
// Shared constants and helpers for the fast inverse square root pipeline.
package fis_pkg;

    localparam logic [31:0] GUESS_MAGIC  = 32'h5f37_59df;
    localparam logic [31:0] FP_HALF      = 32'h3f00_0000;
    localparam logic [31:0] FP_THREE_HLF = 32'h3fc0_0000;
    localparam logic [31:0] FP_DEF_NAN   = 32'hffc0_0000;
    localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;

    localparam int UNIT_DEPTH  = 3;
    localparam int PIPE_DEPTH  = 5 * UNIT_DEPTH;
    localparam int GUESS_DEPTH = 4 * UNIT_DEPTH;

    // leading zeros of a 24-bit significand (24 when zero)
    function automatic logic [4:0] lzc24(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    // leading zeros of a 28-bit sum (28 when zero)
    function automatic logic [4:0] lzc28(input logic [27:0] m);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (m[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    // bit-level first guess: magic minus operand shifted right arithmetically
    function automatic logic [31:0] first_guess(input logic [31:0] b);
        return GUESS_MAGIC - {b[31], b[31:1]};
    endfunction

endpackage

// File: src/fis_fmul.sv
// Three-stage single-precision multiplier, round to nearest even, IEEE subnormals.
module fis_fmul (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);
    import fis_pkg::*;

    // stage A: unpack, normalize significands, catch special operands
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    logic signed [9:0] ena, enb;
    logic [31:0] n_spec_val;
    logic        n_spec;

    assign a_nan  = (i_a[30:23] == 8'hff) && (i_a[22:0] != 23'd0);
    assign b_nan  = (i_b[30:23] == 8'hff) && (i_b[22:0] != 23'd0);
    assign a_inf  = (i_a[30:23] == 8'hff) && (i_a[22:0] == 23'd0);
    assign b_inf  = (i_b[30:23] == 8'hff) && (i_b[22:0] == 23'd0);
    assign a_zero = (i_a[30:0] == 31'd0);
    assign b_zero = (i_b[30:0] == 31'd0);
    assign ma     = {i_a[30:23] != 8'd0, i_a[22:0]};
    assign mb     = {i_b[30:23] != 8'd0, i_b[22:0]};
    assign lza    = lzc24(ma);
    assign lzb    = lzc24(mb);
    assign ena    = $signed({2'b00, (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23]})
                  - $signed({5'd0, lza});
    assign enb    = $signed({2'b00, (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]})
                  - $signed({5'd0, lzb});

    always_comb begin
        n_spec     = 1'b1;
        n_spec_val = {i_a[31] ^ i_b[31], 31'd0};
        priority if (a_nan) begin
            n_spec_val = i_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            n_spec_val = i_b | FP_QUIET_BIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            n_spec_val = FP_DEF_NAN;
        end else if (a_inf || b_inf) begin
            n_spec_val = {i_a[31] ^ i_b[31], 8'hff, 23'd0};
        end else if (a_zero || b_zero) begin
            n_spec_val = {i_a[31] ^ i_b[31], 31'd0};
        end else begin
            n_spec = 1'b0;
        end
    end

    logic        r_a_spec, r_a_sign;
    logic [31:0] r_a_sval;
    logic [23:0] r_a_ma, r_a_mb;
    logic signed [10:0] r_a_exp;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_spec <= n_spec;
            r_a_sval <= n_spec_val;
            r_a_sign <= i_a[31] ^ i_b[31];
            r_a_ma   <= ma << lza;
            r_a_mb   <= mb << lzb;
            r_a_exp  <= 11'(ena) + 11'(enb) - 11'sd127;
        end
    end

    // stage B: significand product
    logic        r_b_spec, r_b_sign;
    logic [31:0] r_b_sval;
    logic [47:0] r_b_prod;
    logic signed [10:0] r_b_exp;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_b_spec <= r_a_spec;
            r_b_sval <= r_a_sval;
            r_b_sign <= r_a_sign;
            r_b_prod <= r_a_ma * r_a_mb;
            r_b_exp  <= r_a_exp;
        end
    end

    // stage C: normalize, denormalize on underflow, round
    logic signed [10:0] e2;
    logic [47:0] p2, sft, msk;
    logic [10:0] shv;
    logic [4:0]  shc;
    logic        lost, grd, stk, inc, tiny;
    logic [23:0] keep;
    logic [24:0] rsum;
    logic [31:0] n_y;
    logic signed [10:0] ef;

    always_comb begin
        p2   = r_b_prod[47] ? r_b_prod : {r_b_prod[46:0], 1'b0};
        e2   = r_b_exp + 11'(r_b_prod[47]);
        tiny = (e2 <= 11'sd0);
        shv  = tiny ? 11'(11'sd1 - e2) : 11'd0;
        shc  = (shv > 11'd26) ? 5'd26 : shv[4:0];
        msk  = (48'd1 << shc) - 48'd1;
        lost = |(p2 & msk);
        sft  = p2 >> shc;
        keep = sft[47:24];
        grd  = sft[23];
        stk  = (|sft[22:0]) | lost;
        inc  = grd & (stk | keep[0]);
        rsum = {1'b0, keep} + 25'(inc);
        ef   = e2 + 11'(rsum[24]);
        if (r_b_spec) begin
            n_y = r_b_sval;
        end else if (tiny) begin
            n_y = {r_b_sign, 7'd0, rsum[23], rsum[22:0]};
        end else if (ef >= 11'sd255) begin
            n_y = {r_b_sign, 8'hff, 23'd0};
        end else begin
            n_y = {r_b_sign, ef[7:0], rsum[24] ? 23'd0 : rsum[22:0]};
        end
    end

    logic [31:0] r_y;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_y <= n_y;
        end
    end
    assign o_y = r_y;

endmodule

// File: src/fis_fsub.sv
// Three-stage single-precision subtractor a - b, round to nearest even.
module fis_fsub (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);
    import fis_pkg::*;

    // stage A: specials, swap by magnitude, align smaller operand
    logic [31:0] bn;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swp;
    logic [31:0] lg, sm;
    logic [7:0]  el, es, dd;
    logic [4:0]  dc;
    logic [26:0] ml, ms, msk, msh;
    logic        n_spec;
    logic [31:0] n_sval;

    assign bn    = {~i_b[31], i_b[30:0]};
    assign a_nan = (i_a[30:23] == 8'hff) && (i_a[22:0] != 23'd0);
    assign b_nan = (i_b[30:23] == 8'hff) && (i_b[22:0] != 23'd0);
    assign a_inf = (i_a[30:23] == 8'hff) && (i_a[22:0] == 23'd0);
    assign b_inf = (i_b[30:23] == 8'hff) && (i_b[22:0] == 23'd0);
    assign swp   = bn[30:0] > i_a[30:0];
    assign lg    = swp ? bn : i_a;
    assign sm    = swp ? i_a : bn;
    assign el    = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    assign es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    assign dd    = el - es;
    assign dc    = (dd > 8'd27) ? 5'd27 : dd[4:0];
    assign ml    = {lg[30:23] != 8'd0, lg[22:0], 3'b000};
    assign ms    = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
    assign msk   = (27'd1 << dc) - 27'd1;
    assign msh   = (ms >> dc) | 27'(|(ms & msk));

    always_comb begin
        n_spec = 1'b1;
        n_sval = i_a;
        priority if (a_nan) begin
            n_sval = i_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            n_sval = i_b | FP_QUIET_BIT;
        end else if (a_inf && b_inf && (i_a[31] != bn[31])) begin
            n_sval = FP_DEF_NAN;
        end else if (a_inf) begin
            n_sval = i_a;
        end else if (b_inf) begin
            n_sval = bn;
        end else begin
            n_spec = 1'b0;
        end
    end

    logic        r_a_spec, r_a_sign, r_a_sub, r_a_zsgn;
    logic [31:0] r_a_sval;
    logic [7:0]  r_a_exp;
    logic [26:0] r_a_ml, r_a_ms;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_spec <= n_spec;
            r_a_sval <= n_sval;
            r_a_sign <= lg[31];
            r_a_sub  <= lg[31] != sm[31];
            r_a_zsgn <= i_a[31] & bn[31];
            r_a_exp  <= el;
            r_a_ml   <= ml;
            r_a_ms   <= msh;
        end
    end

    // stage B: add or subtract significands, count leading zeros
    logic [27:0] sum;
    assign sum = r_a_sub ? ({1'b0, r_a_ml} - {1'b0, r_a_ms})
                         : ({1'b0, r_a_ml} + {1'b0, r_a_ms});

    logic        r_b_spec, r_b_sign, r_b_zsgn;
    logic [31:0] r_b_sval;
    logic [7:0]  r_b_exp;
    logic [27:0] r_b_sum;
    logic [4:0]  r_b_lz;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_b_spec <= r_a_spec;
            r_b_sval <= r_a_sval;
            r_b_sign <= r_a_sign;
            r_b_zsgn <= r_a_zsgn;
            r_b_exp  <= r_a_exp;
            r_b_sum  <= sum;
            r_b_lz   <= lzc28(sum);
        end
    end

    // stage C: normalize, round, pack
    logic [26:0] m27;
    logic [8:0]  e9, ef;
    logic [7:0]  shl, lzm1, em1;
    logic        grd, stk, inc;
    logic [24:0] rsum;
    logic [31:0] n_y;

    always_comb begin
        lzm1 = {3'd0, r_b_lz} - 8'd1;
        em1  = r_b_exp - 8'd1;
        shl  = (lzm1 < em1) ? lzm1 : em1;
        if (r_b_sum[27]) begin
            m27 = {r_b_sum[27:2], r_b_sum[1] | r_b_sum[0]};
            e9  = {1'b0, r_b_exp} + 9'd1;
        end else begin
            m27 = r_b_sum[26:0] << shl;
            e9  = {1'b0, r_b_exp} - {1'b0, shl};
        end
        grd  = m27[2];
        stk  = |m27[1:0];
        inc  = grd & (stk | m27[3]);
        rsum = {1'b0, m27[26:3]} + 25'(inc);
        ef   = e9 + 9'(rsum[24]);
        if (r_b_spec) begin
            n_y = r_b_sval;
        end else if (r_b_sum == 28'd0) begin
            n_y = {r_b_zsgn, 31'd0};
        end else if (!m27[26]) begin
            n_y = {r_b_sign, 7'd0, rsum[23], rsum[22:0]};
        end else if (ef >= 9'd255) begin
            n_y = {r_b_sign, 8'hff, 23'd0};
        end else begin
            n_y = {r_b_sign, ef[7:0], rsum[24] ? 23'd0 : rsum[22:0]};
        end
    end

    logic [31:0] r_y;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_y <= n_y;
        end
    end
    assign o_y = r_y;

endmodule

// File: src/fast_inverse_sqrt.sv
// Top level: streaming fast reciprocal square root, bit-guess plus one Newton step.
//
// Usage:
//  Slave channel (i_s_*) takes one request per cycle while o_s_tready is high:
//  the 32-bit pattern of a single-precision operand. Master channel (o_m_*)
//  returns the 32-bit pattern of the approximate 1/sqrt(x), one result per
//  request, in request order. Datapath: guess = 0x5f3759df - (x >>> 1);
//  half = x*0.5; p = half*g; q = p*g; d = 1.5 - q; y = g*d. Four multipliers
//  and one subtractor in a chain, each three register stages deep, all IEEE
//  round-to-nearest-even.
//  Throughput: one request per cycle while i_m_tready does not stall the output.
//  Reset (i_rst_n low, synchronous) clears every valid bit; payload
//  registers are left as they are.
//  Stall: when the output holds a result and i_m_tready is low, the whole
//  pipe freezes (one shared enable) and o_s_tready drops; nothing is lost
//  or repeated. Empty slots at the output do not block the pipe.
module fast_inverse_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] operand_bits
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] result_bits
);
    import fis_pkg::*;

    logic ce;
    logic [PIPE_DEPTH-1:0] r_vld;

    // advance whenever the output slot is empty or being drained
    assign ce         = !r_vld[PIPE_DEPTH-1] || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    // guess travels beside the arithmetic to meet each multiplier that uses it
    logic [31:0] r_g [GUESS_DEPTH];
    logic [31:0] guess;
    assign guess = first_guess(i_s_tdata);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_g[0] <= guess;
            for (int k = 1; k < GUESS_DEPTH; k++) begin
                r_g[k] <= r_g[k-1];
            end
        end
    end

    logic [31:0] half_x, prod_p, prod_q, diff_d, res_y;

    fis_fmul u_mul_half (
        .i_clk(i_clk), .i_ce(ce), .i_a(i_s_tdata), .i_b(FP_HALF), .o_y(half_x)
    );

    fis_fmul u_mul_p (
        .i_clk(i_clk), .i_ce(ce), .i_a(half_x), .i_b(r_g[UNIT_DEPTH-1]),
        .o_y(prod_p)
    );

    fis_fmul u_mul_q (
        .i_clk(i_clk), .i_ce(ce), .i_a(prod_p), .i_b(r_g[2*UNIT_DEPTH-1]),
        .o_y(prod_q)
    );

    fis_fsub u_sub_d (
        .i_clk(i_clk), .i_ce(ce), .i_a(FP_THREE_HLF), .i_b(prod_q), .o_y(diff_d)
    );

    fis_fmul u_mul_y (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_g[GUESS_DEPTH-1]), .i_b(diff_d), .o_y(res_y)
    );

    assign o_m_tdata = res_y;

    // pipe frozen: first stage keeps its valid
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ce && r_vld[0]) |=> r_vld[0])
        else $error("stage valid lost during stall");

    // advancing pipe moves the valid of the last-but-one stage into the output stage
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ce && r_vld[PIPE_DEPTH-2]) |=> o_m_tvalid)
        else $error("valid did not reach output");

    // reset empties the pipe; the output valid is checked low after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the streaming fast reciprocal square root unit.
`timescale 1ns / 1ps

module testbench;
    import fis_pkg::*;

    localparam int N_RANDOM   = 480;
    localparam int DRAIN_WAIT = 2 * PIPE_DEPTH + 10;
    localparam int STALL_MAX  = 2000;   // cycles with no transfer on either side
    localparam int LONG_HOLD  = 60;     // long receiver hold-off, fills the pipe

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;    // [31:0] operand_bits
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;    // [31:0] result_bits

    // Scoreboard: bit-exact single-precision model plus in-order result queue.
    class rsqrt_board;
        logic [31:0] expected_roots[$];
        int          n_errors;

        function new();
            n_errors = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
            n_errors++;
        endtask

        function automatic bit is_nan(logic [31:0] b);
            return b[30:23] == 8'hff && b[22:0] != 0;
        endfunction

        function automatic bit is_inf(logic [31:0] b);
            return b[30:0] == 31'h7f80_0000;
        endfunction

        function automatic bit is_zero(logic [31:0] b);
            return b[30:0] == 0;
        endfunction

        function automatic logic [23:0] sig_of(logic [31:0] b);
            return {b[30:23] != 0, b[22:0]};
        endfunction

        // value = sig_of(b) * 2^exp_of(b)
        function automatic int exp_of(logic [31:0] b);
            return (b[30:23] == 0 ? 1 : int'(b[30:23])) - 150;
        endfunction

        // round sgn * mag * 2^e to nearest even and pack
        function automatic logic [31:0] round_pack(bit sgn, logic [299:0] mag, int e);
            int          msb;
            int          sh;
            int          e0;
            int          bexp;
            logic [299:0] q;
            logic [299:0] rem;
            logic [299:0] hlf;
            if (mag == 0) return {sgn, 31'd0};
            msb = 0;
            for (int i = 0; i < 300; i++) if (mag[i]) msb = i;
            sh = msb - 23;
            if (-149 - e > sh) sh = -149 - e;   // subnormal range floors the ulp
            if (sh > 0) begin
                q   = mag >> sh;
                rem = mag - (q << sh);
                hlf = 300'd1 << (sh - 1);
                if (rem > hlf || (rem == hlf && q[0])) q = q + 1;
            end else begin
                q = mag << (-sh);
            end
            e0 = e + sh;
            if (q[24]) begin
                q  = q >> 1;
                e0 = e0 + 1;
            end
            if (!q[23]) return {sgn, 8'd0, q[22:0]};
            bexp = e0 + 150;
            if (bexp >= 255) return {sgn, 8'hff, 23'd0};
            return {sgn, bexp[7:0], q[22:0]};
        endfunction

        function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
            bit sgn;
            if (is_nan(a)) return a | FP_QUIET_BIT;
            if (is_nan(b)) return b | FP_QUIET_BIT;
            sgn = a[31] ^ b[31];
            if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return FP_DEF_NAN;
            if (is_inf(a) || is_inf(b)) return {sgn, 8'hff, 23'd0};
            return round_pack(sgn, 300'(sig_of(a)) * 300'(sig_of(b)), exp_of(a) + exp_of(b));
        endfunction

        function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
            int           emin;
            bit           sa;
            bit           sb;
            logic [299:0] ma;
            logic [299:0] mb;
            if (is_nan(a)) return a | FP_QUIET_BIT;
            if (is_nan(b)) return b | FP_QUIET_BIT;
            if (is_inf(a) && is_inf(b) && a[31] == b[31]) return FP_DEF_NAN;
            if (is_inf(a)) return a;
            if (is_inf(b)) return {~b[31], b[30:0]};
            if (is_zero(a) && is_zero(b)) return {a[31] & ~b[31], 31'd0};
            sa   = a[31];
            sb   = ~b[31];
            emin = exp_of(a) < exp_of(b) ? exp_of(a) : exp_of(b);
            ma   = 300'(sig_of(a)) << (exp_of(a) - emin);
            mb   = 300'(sig_of(b)) << (exp_of(b) - emin);
            if (sa == sb) return round_pack(sa, ma + mb, emin);
            if (ma == mb) return 32'd0;         // exact cancel gives +0
            if (ma > mb) return round_pack(sa, ma - mb, emin);
            return round_pack(sb, mb - ma, emin);
        endfunction

        function automatic logic [31:0] predict_root(logic [31:0] x);
            logic [31:0] hx;
            logic [31:0] g;
            logic [31:0] p;
            logic [31:0] q;
            hx = fp_mul(x, FP_HALF);
            g  = GUESS_MAGIC - {x[31], x[31:1]};
            p  = fp_mul(hx, g);
            q  = fp_mul(p, g);
            return fp_mul(g, fp_sub(FP_THREE_HLF, q));
        endfunction

        function void note_operand(logic [31:0] x);
            expected_roots.push_back(predict_root(x));
        endfunction

        task check_result(logic [31:0] y);
            logic [31:0] want;
            if (expected_roots.size() == 0) begin
                report("unexpected result", y, 32'd0);
            end else begin
                want = expected_roots.pop_front();
                if (y !== want) report("result_bits", y, want);
            end
        endtask
    endclass

    rsqrt_board board;
    bit         idle_on;       // idling on or off for the current stretch
    int         n_results;
    int         quiet_cycles;

    fast_inverse_sqrt u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) board.note_operand(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata);
            n_results++;
        end
    end

    // watchdog: ends the run when no request or result moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request: optional gap with valid low, then hold until accepted
    task send_operand(logic [31:0] x);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = x;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // random float-ish operand: moderate, tiny or huge positives, or raw noise
    function automatic logic [31:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return {1'b0, 8'($urandom_range(90, 170)), 23'($urandom)};
        if (sel < 7) return {1'b0, 8'($urandom_range(0, 3)), 23'($urandom)};
        if (sel < 8) return {1'b0, 8'($urandom_range(240, 255)), 23'($urandom)};
        return $urandom;
    endfunction

    // receiver: random stalls, one long hold-off, stall-free stretches
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (n_results == 150) begin
                i_m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            @(negedge i_clk);
        end
    end

    initial begin
        logic [31:0] corner[$];
        board        = new();
        n_results    = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 32'd0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zeros, infinities, NaNs (quiet and signaling), subnormal edges,
        // largest finite, negatives (sign joins the shift), a guess that is NaN,
        // guess wrap on all-ones
        corner = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                   32'h7fc0_0000, 32'h7f80_0001, 32'hffbf_ffff, 32'hffff_ffff,
                   32'h0000_0001, 32'h007f_ffff, 32'h0080_0000, 32'h7f7f_ffff,
                   32'h3f80_0000, 32'h4080_0000, 32'hbf80_0000, 32'h5f37_59df,
                   32'hbeee_b3be, 32'h3e80_0000, 32'h8000_0001, 32'hffff_fffe,
                   32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
        foreach (corner[i]) send_operand(corner[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) idle_on = (i / 100) % 2 == 0;
            send_operand(pick_operand());
        end
        i_s_tvalid = 1'b0;
        idle_on    = 1'b1;

        while (board.expected_roots.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (board.n_errors == 0 && board.expected_roots.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
